@@ hdl/cicd_pkg.sv @@
// Package: shared types and constants for the CIC decimator.
package cicd_pkg;

  localparam int unsigned ACC_W   = 32;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned RATIO_W = 7;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned RES_W   = 16;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [RATIO_W-1:0] RATIO_MAX   = 7'd64;
  localparam logic [RATIO_W-1:0] RATIO_RST   = 7'd25;
  localparam logic [SHIFT_W-1:0] SHIFT_RST   = 5'd8;
  localparam logic [OFS_W-1:0]   OFFSET_RST  = 16'h5C00;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_RATIO  = 2'd0,
    CFG_SHIFT  = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_idx_t;

  // Item moving down the integrator row: running value plus end-of-period tag
  typedef struct packed {
    logic             dump;
    logic [ACC_W-1:0] val;
  } tok_t;

endpackage

@@ hdl/cicd_in_if.sv @@
// Interface: input sample channel.
interface cicd_in_if import cicd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

@@ hdl/cicd_out_if.sv @@
// Interface: filtered result channel.
interface cicd_out_if import cicd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface

@@ hdl/cicd_cfg_if.sv @@
// Interface: configuration write channel.
interface cicd_cfg_if import cicd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [OFS_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/cicd_integ_cell.sv @@
// Integrator cell: wrapping accumulator that passes its updated sum downstream.
module cicd_integ_cell import cicd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  logic             valid_r, valid_nxt;
  logic             dump_r, dump_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             take;

  // Stage frees up when empty or when its item moves on
  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    dump_nxt  = dump_r;
    acc_nxt   = acc_r;
    if (take) begin
      valid_nxt = 1'b1;
      dump_nxt  = in_tok.dump;
      acc_nxt   = acc_r + in_tok.val;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      acc_r   <= acc_nxt;
    end
    dump_r <= dump_nxt;
  end

  assign out_valid    = valid_r;
  assign out_tok.dump = dump_r;
  assign out_tok.val  = acc_r;

endmodule

@@ hdl/cicd_comb_cell.sv @@
// Comb cell: first difference with a delay of one item.
module cicd_comb_cell import cicd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACC_W-1:0] in_val,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ACC_W-1:0] out_val
);

  logic             valid_r, valid_nxt;
  logic [ACC_W-1:0] dly_r, dly_nxt;
  logic [ACC_W-1:0] diff_r, diff_nxt;
  logic             take;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    dly_nxt   = dly_r;
    diff_nxt  = diff_r;
    if (take) begin
      valid_nxt = 1'b1;
      dly_nxt   = in_val;
      diff_nxt  = in_val - dly_r;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dly_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      dly_r   <= dly_nxt;
    end
    diff_r <= diff_nxt;
  end

  assign out_valid = valid_r;
  assign out_val   = diff_r;

endmodule

@@ hdl/cic_decimator_third_order_top.sv @@
// Top level: CIC decimator built from a row of integrator cells and comb cells.
//
//   channel   dir   handshake      payload
//   in_if     in    valid/ready    sample_in    (16 b, low SAMPLE_BITS used)
//   out_if    out   valid/ready    filtered_out (16 b signed)
//   cfg_if    in    valid/ready    index (2 b), data (16 b); ready always high
//
// One sample is taken per clock while in_if.ready is high; each cell is one
// register stage, and the output register adds one more. Reset (synchronous,
// rst_n low) clears all integrators, comb delays, the sample counter and
// restores the register defaults. Stalls on out_if back up cell by cell;
// samples keep being taken while empty cells remain.
module cic_decimator_third_order_top import cicd_pkg::*; #(
  parameter int unsigned STAGES      = 3,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  cicd_in_if.sink     in_if,
  cicd_out_if.source  out_if,
  cicd_cfg_if.sink    cfg_if
);

  // Configuration registers
  logic [RATIO_W-1:0] ratio_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [OFS_W-1:0]   offset_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= RATIO_RST;
      shift_r  <= SHIFT_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_RATIO:  ratio_r  <= cfg_if.data[RATIO_W-1:0];
        CFG_SHIFT:  shift_r  <= cfg_if.data[SHIFT_W-1:0];
        CFG_OFFSET: offset_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Effective ratio: zero acts as one, large values clamp
  logic [RATIO_W-1:0] eff_ratio;
  always_comb begin
    if (ratio_r == '0) begin
      eff_ratio = RATIO_W'(1);
    end else if (ratio_r > RATIO_MAX) begin
      eff_ratio = RATIO_MAX;
    end else begin
      eff_ratio = ratio_r;
    end
  end

  // Integrator row
  tok_t itok   [STAGES+1];
  logic ivalid [STAGES+1];
  logic iready [STAGES+1];

  // Sample counter tags the item that closes each period
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RATIO_W-1:0] cnt_plus;
  logic               dump;
  logic               in_take;

  assign in_take  = in_if.valid && iready[0];
  assign cnt_plus = {1'b0, cnt_r} + RATIO_W'(1);
  assign dump     = (cnt_plus >= eff_ratio);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_take) begin
      cnt_nxt = dump ? '0 : cnt_plus[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign in_if.ready   = iready[0];
  assign ivalid[0]     = in_if.valid;
  assign itok[0].dump  = dump;
  assign itok[0].val   = ACC_W'(in_if.sample_in[SAMPLE_BITS-1:0]);

  for (genvar i = 0; i < STAGES; i++) begin : g_integ
    cicd_integ_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ivalid[i]),
      .in_ready  (iready[i]),
      .in_tok    (itok[i]),
      .out_valid (ivalid[i+1]),
      .out_ready (iready[i+1]),
      .out_tok   (itok[i+1])
    );
  end

  // Comb row: only period-closing items enter, the rest are dropped here
  logic [ACC_W-1:0] cval   [STAGES+1];
  logic             cvalid [STAGES+1];
  logic             cready [STAGES+1];

  assign cvalid[0]      = ivalid[STAGES] && itok[STAGES].dump;
  assign cval[0]        = itok[STAGES].val;
  assign iready[STAGES] = itok[STAGES].dump ? cready[0] : 1'b1;

  for (genvar i = 0; i < STAGES; i++) begin : g_comb
    cicd_comb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cvalid[i]),
      .in_ready  (cready[i]),
      .in_val    (cval[i]),
      .out_valid (cvalid[i+1]),
      .out_ready (cready[i+1]),
      .out_val   (cval[i+1])
    );
  end

  // Output register: scale, remove offset, keep low 16 bits
  logic             ovalid_r, ovalid_nxt;
  logic [RES_W-1:0] odata_r, odata_nxt;
  logic [ACC_W-1:0] shifted;

  assign cready[STAGES] = !ovalid_r || out_if.ready;
  assign shifted        = cval[STAGES] >> shift_r;

  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (cvalid[STAGES] && cready[STAGES]) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = shifted[RES_W-1:0] - offset_r;
    end else if (out_if.ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
    odata_r <= odata_nxt;
  end

  assign out_if.valid        = ovalid_r;
  assign out_if.filtered_out = odata_r;

endmodule
